// ----- rtl/spira_pkg.sv -----
// Shared types and constants for the serial register-access master.
// Used by spira_core, spira_skid and spi_register_access_master.
`timescale 1ns / 1ps

package spira_pkg;

    // Frame geometry
    localparam int DATA_BITS  = 8;
    localparam int FRAME_BITS = 2 * DATA_BITS;
    localparam int ADDR_BITS  = 6;
    localparam int TICK_W     = 6;

    // Tick numbering inside an active frame
    localparam logic [TICK_W-1:0] FIRST_BIT_TICK    = TICK_W'(1);
    localparam logic [TICK_W-1:0] LAST_BIT_TICK     = TICK_W'(2 * FRAME_BITS);
    localparam logic [TICK_W-1:0] TRAIL_TICK        = TICK_W'(2 * FRAME_BITS + 1);
    localparam logic [TICK_W-1:0] SAMPLE_FIRST_TICK = TICK_W'(2 * (DATA_BITS + 1));

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Access kind carried in the instruction byte
    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    // One input item: one half-bit tick
    typedef struct packed
    {
        logic                 miso_bit;
        logic [DATA_BITS-1:0] write_data;
        logic [ADDR_BITS-1:0] address;
        op_t                  operation;
        logic                 start_req;
    } item_t;

    // One result item: pin levels and status for the tick
    typedef struct packed
    {
        logic                 done_res;
        logic [DATA_BITS-1:0] read_data;
        logic                 busy_res;
        logic                 sen_n;
        logic                 mosi;
        logic                 sclk;
    } result_t;

endpackage

// ----- rtl/spi_register_access_master.sv -----
// Top level of the serial register-access master.
// Depends on spira_pkg, spira_core and spira_skid.
`timescale 1ns / 1ps

// Usage:
// Each input item on the s_ channel is one half-bit pin tick, normally paced
// by a clock-enable divider. An idle tick with start_req set latches a read
// or write, the address and the write byte, and drives the leading tick with
// sen_n low. Sixteen bits follow MSB first, each a clock-low then clock-high
// tick, then one trailing clock-low tick and a final tick with sen_n high
// that sets done (m_tlast). A frame thus spans 35 items. On a read, miso_bit
// is sampled on the clock-high tick of the last 8 bits.
// Every input item yields exactly one result item on the m_ channel.
// An accepted item's result is registered in the output register, or in the
// skid slot when that is held. One item per cycle while s_tready is high.
// When the receiver stalls, one result waits in the output register and one
// more in a skid slot; s_tready falls only when both are full and rises as
// soon as the receiver takes a result.
// Reset clears the sequencer to idle, read_data to zero and empties both
// output slots.

module spi_register_access_master
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: start_req[0], address[6:1], write_data[14:7], miso_bit[15]
    input  logic [spira_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: operation[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: sclk[0], mosi[1], sen_n[2], busy_res[3], read_data[11:4], zeros[15:12]
    output logic [spira_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tlast: done_res
    output logic                            m_tlast
);
    import spira_pkg::*;

    item_t   item;
    result_t core_result;
    result_t out_result;
    logic    advance;

    // Unpack the input item
    assign item.start_req  = s_tdata[0];
    assign item.operation  = op_t'(s_tuser);
    assign item.address    = s_tdata[ADDR_BITS:1];
    assign item.write_data = s_tdata[ADDR_BITS+DATA_BITS:ADDR_BITS+1];
    assign item.miso_bit   = s_tdata[ADDR_BITS+DATA_BITS+1];

    assign advance = s_tvalid && s_tready;

    spira_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (core_result)
    );

    spira_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack the result item
    assign m_tdata = {4'b0000, out_result.read_data, out_result.busy_res,
                      out_result.sen_n, out_result.mosi, out_result.sclk};
    assign m_tlast = out_result.done_res;

`ifndef SYNTHESIS
    // A frame-done tick has enable released and is not busy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[2] && !m_tdata[3])
        else $error("done tick with enable low or busy set");

    // Serial clock high only inside a frame with enable low
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[2] && m_tdata[3])
        else $error("sclk high outside an active frame");

    // Input stalls only while the output register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output register");
`endif

endmodule

// ----- rtl/spira_core.sv -----
// Frame sequencer: tick counter, frame shifter and read-byte assembler.
// Depends on spira_pkg. Result is combinational from state and the item.
`timescale 1ns / 1ps

module spira_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  spira_pkg::item_t item,
    output spira_pkg::result_t result
);
    import spira_pkg::*;

    logic [TICK_W-1:0]     tick_reg,    tick_next;
    logic [FRAME_BITS-1:0] frame_reg,   frame_next;
    logic                  is_read_reg, is_read_next;
    logic [DATA_BITS-1:0]  sampled_reg, sampled_next;
    logic                  active_reg,  active_next;
    logic [DATA_BITS-1:0]  instr;

    // Instruction byte: read flag, zero, address
    assign instr = {item.operation == OP_READ, 1'b0, item.address};

    // Work out the pins for this tick and the next state
    always_comb
    begin
        tick_next    = tick_reg;
        frame_next   = frame_reg;
        is_read_next = is_read_reg;
        sampled_next = sampled_reg;
        active_next  = active_reg;
        result.sclk      = 1'b0;
        result.mosi      = 1'b0;
        result.sen_n     = 1'b1;
        result.busy_res  = 1'b0;
        result.done_res  = 1'b0;

        if (!active_reg)
        begin
            if (item.start_req)
            begin
                is_read_next = (item.operation == OP_READ);
                frame_next   = {instr, (item.operation == OP_READ) ? '0 : item.write_data};
                if (item.operation == OP_READ)
                begin
                    sampled_next = '0;
                end
                active_next     = 1'b1;
                tick_next       = FIRST_BIT_TICK;
                result.sen_n    = 1'b0;
                result.busy_res = 1'b1;
            end
        end
        else if (tick_reg >= FIRST_BIT_TICK && tick_reg <= LAST_BIT_TICK)
        begin
            result.mosi     = frame_reg[FRAME_BITS-1];
            result.sen_n    = 1'b0;
            result.busy_res = 1'b1;
            // Clock-high tick: sample on data half of a read, then shift
            if (!tick_reg[0])
            begin
                result.sclk = 1'b1;
                if (is_read_reg && tick_reg >= SAMPLE_FIRST_TICK)
                begin
                    sampled_next = {sampled_reg[DATA_BITS-2:0], item.miso_bit};
                end
                frame_next = {frame_reg[FRAME_BITS-2:0], 1'b0};
            end
            tick_next = tick_reg + TICK_W'(1);
        end
        else if (tick_reg == TRAIL_TICK)
        begin
            result.sen_n    = 1'b0;
            result.busy_res = 1'b1;
            tick_next       = tick_reg + TICK_W'(1);
        end
        else
        begin
            result.done_res = 1'b1;
            active_next     = 1'b0;
            tick_next       = '0;
        end

        result.read_data = sampled_next;
    end

    // Hold state; advance only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            frame_reg   <= '0;
            is_read_reg <= 1'b0;
            sampled_reg <= '0;
            active_reg  <= 1'b0;
        end
        else if (advance)
        begin
            tick_reg    <= tick_next;
            frame_reg   <= frame_next;
            is_read_reg <= is_read_next;
            sampled_reg <= sampled_next;
            active_reg  <= active_next;
        end
    end

endmodule

// ----- rtl/spira_skid.sv -----
// Two-entry output register with skid slot for result items.
// Depends on spira_pkg. Input ready depends only on the skid slot.
`timescale 1ns / 1ps

module spira_skid
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  spira_pkg::result_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output spira_pkg::result_t  out_data
);
    import spira_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_fire;
    logic    out_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control: output slot and skid slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!in_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: refill output from skid, else from the incoming item, which goes to the skid slot while output is held
    always_ff @(posedge clk)
    begin
        if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (in_fire && (out_fire || !out_valid_reg))
        begin
            out_data_reg <= in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for spi_register_access_master: drives half-bit ticks,
// predicts the pin levels of every tick and compares them with the m_ stream.
// Depends on spira_pkg and the RTL of spi_register_access_master.
`timescale 1ns / 1ps

import spira_pkg::*;

// Pin-level predictor plus the queue of pin states still owed by the block
class pin_tick_scoreboard;
    logic [TICK_W-1:0]     tick_count;
    logic [FRAME_BITS-1:0] frame_shift;
    logic                  is_read;
    logic [DATA_BITS-1:0]  sampled_byte;
    logic                  active;
    result_t               expected_pins[$];
    int                    errors;
    int                    ticks_seen;
    int                    frames_started;
    int                    reads_started;
    int                    frames_done;

    function new();
        tick_count     = '0;
        frame_shift    = '0;
        is_read        = 1'b0;
        sampled_byte   = '0;
        active         = 1'b0;
        errors         = 0;
        ticks_seen     = 0;
        frames_started = 0;
        reads_started  = 0;
        frames_done    = 0;
    endfunction

    // Advance the frame sequencer by one accepted tick and queue its pins
    function void note_tick(item_t it);
        result_t pins;
        pins       = '0;
        pins.sen_n = 1'b1;
        ticks_seen++;
        if (!active)
        begin
            // Latch a new access; this tick is the leading enable-low tick
            if (it.start_req)
            begin
                is_read     = (it.operation == OP_READ);
                frame_shift = {is_read, 1'b0, it.address,
                               is_read ? {DATA_BITS{1'b0}} : it.write_data};
                if (is_read)
                begin
                    sampled_byte = '0;
                    reads_started++;
                end
                frames_started++;
                active     = 1'b1;
                tick_count = FIRST_BIT_TICK;
                pins.sen_n = 1'b0;
                pins.busy_res = 1'b1;
            end
        end
        else if (tick_count >= FIRST_BIT_TICK && tick_count <= LAST_BIT_TICK)
        begin
            // Bit ticks: clock low on odd counts, clock high and shift on even
            pins.mosi     = frame_shift[FRAME_BITS-1];
            pins.sen_n    = 1'b0;
            pins.busy_res = 1'b1;
            if (!tick_count[0])
            begin
                pins.sclk = 1'b1;
                if (is_read && tick_count >= SAMPLE_FIRST_TICK)
                    sampled_byte = {sampled_byte[DATA_BITS-2:0], it.miso_bit};
                frame_shift = frame_shift << 1;
            end
            tick_count = tick_count + TICK_W'(1);
        end
        else if (tick_count == TRAIL_TICK)
        begin
            pins.sen_n    = 1'b0;
            pins.busy_res = 1'b1;
            tick_count    = tick_count + TICK_W'(1);
        end
        else
        begin
            // Enable back high: frame complete
            pins.done_res = 1'b1;
            active        = 1'b0;
            tick_count    = '0;
            frames_done++;
        end
        pins.read_data = sampled_byte;
        expected_pins.push_back(pins);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // Compare one accepted result with the oldest queued pin state
    function void check_pins(logic [15:0] data, logic last);
        result_t want;
        if (expected_pins.size() == 0)
        begin
            $error("result item with nothing expected: tdata %0h tlast %0b", data, last);
            errors++;
            return;
        end
        want = expected_pins.pop_front();
        compare_field("sclk", 32'(want.sclk), 32'(data[0]));
        compare_field("mosi", 32'(want.mosi), 32'(data[1]));
        compare_field("sen_n", 32'(want.sen_n), 32'(data[2]));
        compare_field("busy_res", 32'(want.busy_res), 32'(data[3]));
        compare_field("read_data", 32'(want.read_data), 32'(data[11:4]));
        compare_field("tdata padding", 0, 32'(data[15:12]));
        compare_field("done_res", 32'(want.done_res), 32'(last));
    endfunction
endclass

module testbench;
    localparam int FRAME_TICKS  = int'(TRAIL_TICK) + 1;
    localparam int RANDOM_ITEMS = 1240;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int gap_pct   = 0;
    int stall_pct = 0;
    int random_sent;

    pin_tick_scoreboard pin_board = new();

    spi_register_access_master dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Randomly stall the result side
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pin_board.check_pins(m_tdata, m_tlast);
    end

    function automatic item_t random_tick(bit start);
        item_t it;
        it.start_req  = start;
        it.operation  = op_t'($urandom_range(1));
        it.address    = ADDR_BITS'($urandom_range(63));
        it.write_data = DATA_BITS'($urandom_range(255));
        it.miso_bit   = 1'($urandom_range(1));
        return it;
    endfunction

    // Offer one tick, idling first at the current gap rate, and hold until taken
    task automatic send_tick(input item_t it);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.miso_bit, it.write_data, it.address, it.start_req};
        s_tuser  <= it.operation;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pin_board.note_tick(it);
    endtask

    // One access: start tick, then the rest of the frame with start held
    // high on hold_pct of the ticks and miso carrying miso_byte on the samples
    task automatic send_frame(input op_t op, input logic [ADDR_BITS-1:0] addr,
                              input logic [DATA_BITS-1:0] wdata,
                              input logic [DATA_BITS-1:0] miso_byte, input int hold_pct);
        item_t it;
        it            = random_tick(1'b1);
        it.operation  = op;
        it.address    = addr;
        it.write_data = wdata;
        send_tick(it);
        for (int t = 1; t <= FRAME_TICKS; t++)
        begin
            it = random_tick($urandom_range(99) < hold_pct);
            if (t >= int'(SAMPLE_FIRST_TICK) && t <= int'(LAST_BIT_TICK) && t % 2 == 0)
                it.miso_bit = miso_byte[(int'(LAST_BIT_TICK) - t) / 2];
            send_tick(it);
            random_sent++;
        end
        random_sent++;
    endtask

    task automatic send_idle(input int count);
        item_t it;
        for (int i = 0; i < count; i++)
        begin
            it = random_tick(1'b0);
            send_tick(it);
            random_sent++;
        end
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pin_board.expected_pins.size() != 0);
    endtask

    initial
    begin
        item_t it;
        int    phase;
        int    last_phase;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle ticks with every field at an extreme but no start
        it = '{miso_bit: 1'b1, write_data: 8'hFF, address: 6'h3F,
               operation: OP_READ, start_req: 1'b0};
        send_tick(it);
        it = '{miso_bit: 1'b0, write_data: 8'h00, address: 6'h00,
               operation: OP_WRITE, start_req: 1'b0};
        send_tick(it);
        // Directed: writes at both field extremes, start held through one frame
        send_frame(OP_WRITE, 6'h00, 8'h00, 8'h00, 0);
        send_frame(OP_WRITE, 6'h3F, 8'hFF, 8'hFF, 100);
        // Directed: a read of all ones, a write keeping the byte, then reads of all zeros and a mixed byte
        send_frame(OP_READ, 6'h3F, 8'h00, 8'hFF, 0);
        send_frame(OP_WRITE, 6'h15, 8'h5A, 8'h00, 0);
        send_frame(OP_READ, 6'h00, 8'hFF, 8'h00, 100);
        send_frame(OP_READ, 6'h2A, 8'h3C, 8'hA5, 0);
        send_idle(2);

        // Random frames with occasional idle runs under changing idling patterns
        random_sent = 0;
        last_phase  = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            phase = random_sent * 5 / RANDOM_ITEMS;
            if (phase != last_phase)
            begin
                if (phase == 2)
                    drain_results();
                last_phase = phase;
            end
            case (phase)
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                3: begin gap_pct = 30; stall_pct = 30; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            if ($urandom_range(99) < 85)
                send_frame(op_t'($urandom_range(1)), ADDR_BITS'($urandom_range(63)),
                           DATA_BITS'($urandom_range(255)), DATA_BITS'($urandom_range(255)),
                           $urandom_range(30));
            else
                send_idle($urandom_range(1, 4));
        end

        // Drain, then wait for any stray result
        stall_pct = 0;
        drain_results();
        repeat (8) @(posedge clk);

        $display("Checked %0d ticks over %0d frames (%0d reads), with and without idling.",
                 pin_board.ticks_seen, pin_board.frames_done, pin_board.reads_started);
        if (pin_board.errors == 0 && pin_board.expected_pins.size() == 0)
            $display("spi_register_access_master regression: pass");
        else
            $display("spi_register_access_master regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("spi_register_access_master regression: fail");
        $finish;
    end
endmodule
